// ===== design/pep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pep_pkg
// Shared types and constants of the printer escape parser and layout block.
// ----------------------------------------------------------------------------
package pep_pkg;

  // Control codes of the printer byte stream
  localparam logic [7:0] CODE_EOL         = 8'd155;
  localparam logic [7:0] CODE_ESC         = 8'd27;
  localparam logic [7:0] CODE_UL_ON       = 8'd15;
  localparam logic [7:0] CODE_UL_OFF      = 8'd14;
  localparam logic [7:0] CODE_INTL_ON     = 8'd23;
  localparam logic [7:0] CODE_INTL_OFF    = 8'd24;
  localparam logic [7:0] CODE_ESC_UL_ON   = 8'd25;
  localparam logic [7:0] CODE_ESC_UL_OFF  = 8'd26;

  // Result kinds
  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_EOL   = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_HEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH    = 3'd6;

  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [15:0] MARGIN_LEFT_RST   = 16'd0;
  localparam logic [15:0] MARGIN_RIGHT_RST  = 16'd960;
  localparam logic [15:0] MARGIN_TOP_RST    = 16'd0;
  localparam logic [15:0] MARGIN_BOTTOM_RST = 16'd1320;
  localparam logic [9:0]  CHAR_WIDTH_RST    = 10'd10;
  localparam logic [9:0]  CHAR_HEIGHT_RST   = 10'd17;
  localparam logic [9:0]  LINE_PITCH_RST    = 10'd19;

  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 48;

  typedef struct packed {
    logic [15:0] margin_left;
    logic [15:0] margin_right;
    logic [15:0] margin_top;
    logic [15:0] margin_bottom;
    logic [9:0]  char_width;
    logic [9:0]  char_height;
    logic [9:0]  line_pitch;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic        new_page;
    logic [7:0]  glyph_code;
    logic [15:0] draw_x;
    logic [16:0] draw_y;
    logic        underline_on;
    logic        intl_on;
  } res_t;

endpackage

// ===== design/printer_escape_parser_layout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printer_escape_parser_layout
// Printer byte stream parser with escape handling and pen layout.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one printer byte per transaction in s_axis_tdata, with
//   s_axis_tlast marking the last byte of a host buffer.
//   Master stream: zero or one result per byte; m_axis_tuser carries the kind
//   (glyph or end of line), m_axis_tdata the page flag, glyph code, draw
//   position and mode flags.
//   Config port: write cfg_data_i to register cfg_idx_i while cfg_we_i is high;
//   write only while the block is idle. Unmapped indexes are ignored.
// Timing:
//   A byte is held in the input register and is parsed and laid out
//   combinationally from it; its result is loaded into the result register,
//   which drives the master side. One byte per cycle is sustained while the
//   receiver does not hold off; the pen state loop closes within one parse step.
// Reset:
//   All mode flags clear, pen goes to the reset left and top margins, and the
//   configuration registers take their reset values.
// Stall:
//   When the receiver holds off, the result register holds its transaction,
//   the input register fills, and s_axis_tready drops until space frees.
// ----------------------------------------------------------------------------
module printer_escape_parser_layout (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pep_pkg::TDATA_IN_W-1:0]      s_axis_tdata,   // [7:0] data_byte
  input  logic                                s_axis_tlast,   // last_in_buffer
  // Master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] new_page, [8:1] glyph_code, [24:9] draw_x, [41:25] draw_y,
  // [42] underline_on, [43] intl_on, [47:44] zero
  output logic [pep_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tuser,   // [0] kind
  // Configuration
  input  logic                                cfg_we_i,
  input  logic [pep_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pep_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  pep_pkg::cfg_t  cfg;

  logic           in_valid_q, in_valid_d;
  logic [7:0]     in_byte_q;
  logic           in_last_q;

  logic           out_valid_q, out_valid_d;
  pep_pkg::res_t  out_q;

  logic           out_free;
  logic           step;
  logic           emit;
  pep_pkg::res_t  res;

  pep_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pep_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .cfg_i  (cfg),
    .emit_o (emit),
    .res_o  (res)
  );

  // Advance the held byte whenever the result register can take its result
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) in_valid_d = s_axis_tvalid;
    out_valid_d = out_valid_q;
    if (out_free) out_valid_d = step && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on transaction, hold otherwise
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_last_q <= s_axis_tlast;
    end
    if (step && emit && out_free) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {4'b0000, out_q.intl_on, out_q.underline_on, out_q.draw_y,
                          out_q.draw_x, out_q.glyph_code, out_q.new_page};

`ifndef NO_ASSERTIONS
  // An empty input register always takes a byte
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready) else $error("input stalled while empty");

  // A held byte stays put while the result register is blocked
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |=> (in_valid_q && $stable(in_byte_q)))
    else $error("input byte lost during stall");

  // End of line results carry no glyph, no position and no underline
  a_eol_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind == pep_pkg::KIND_EOL)) |->
      (out_q.glyph_code == 8'd0 && out_q.draw_x == 16'd0 && out_q.draw_y == 17'd0 &&
       !out_q.underline_on))
    else $error("end of line result with glyph payload");
`endif

endmodule

// ===== design/pep_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pep_cfg
// Configuration register file: margins, glyph size and line pitch.
// ----------------------------------------------------------------------------
module pep_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pep_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pep_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output pep_pkg::cfg_t                     cfg_o
);

  pep_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pep_pkg::REG_MARGIN_LEFT:   cfg_d.margin_left   = cfg_data_i;
        pep_pkg::REG_MARGIN_RIGHT:  cfg_d.margin_right  = cfg_data_i;
        pep_pkg::REG_MARGIN_TOP:    cfg_d.margin_top    = cfg_data_i;
        pep_pkg::REG_MARGIN_BOTTOM: cfg_d.margin_bottom = cfg_data_i;
        pep_pkg::REG_CHAR_WIDTH:    cfg_d.char_width    = cfg_data_i[9:0];
        pep_pkg::REG_CHAR_HEIGHT:   cfg_d.char_height   = cfg_data_i[9:0];
        pep_pkg::REG_LINE_PITCH:    cfg_d.line_pitch    = cfg_data_i[9:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.margin_left   <= pep_pkg::MARGIN_LEFT_RST;
      cfg_q.margin_right  <= pep_pkg::MARGIN_RIGHT_RST;
      cfg_q.margin_top    <= pep_pkg::MARGIN_TOP_RST;
      cfg_q.margin_bottom <= pep_pkg::MARGIN_BOTTOM_RST;
      cfg_q.char_width    <= pep_pkg::CHAR_WIDTH_RST;
      cfg_q.char_height   <= pep_pkg::CHAR_HEIGHT_RST;
      cfg_q.line_pitch    <= pep_pkg::LINE_PITCH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/pep_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pep_parser
// Escape decoding, mode flags and pen layout for one byte per cycle while step_i is high.
// ----------------------------------------------------------------------------
module pep_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  input  pep_pkg::cfg_t  cfg_i,
  output logic           emit_o,
  output pep_pkg::res_t  res_o
);

  logic        pend_q, pend_d;
  logic        grab_q, grab_d;
  logic        ul_q, ul_d;
  logic        intl_q, intl_d;
  logic        drop_q, drop_d;
  logic [16:0] pen_x_q, pen_x_d;
  logic [16:0] pen_y_q, pen_y_d;

  logic        is_esc_code;
  logic [17:0] x_reach;
  logic [17:0] y_reach;
  logic        wrap;
  logic        eject;
  logic [16:0] adv_x;
  logic [16:0] adv_y;
  logic [16:0] glyph_x;
  logic [16:0] glyph_y;
  logic        do_glyph;
  logic        do_eol;

  assign is_esc_code = (byte_i == pep_pkg::CODE_INTL_ON)  || (byte_i == pep_pkg::CODE_INTL_OFF) ||
                       (byte_i == pep_pkg::CODE_ESC_UL_ON) || (byte_i == pep_pkg::CODE_ESC_UL_OFF);

  // Pen arithmetic: right margin check, bottom check, line advance
  assign x_reach = {1'b0, pen_x_q} + 18'(cfg_i.char_width);
  assign y_reach = {1'b0, pen_y_q} + 18'(cfg_i.char_height);
  assign wrap    = x_reach > 18'(cfg_i.margin_right);
  assign eject   = y_reach > 18'(cfg_i.margin_bottom);
  assign adv_x   = 17'(cfg_i.margin_left);
  assign adv_y   = eject ? 17'(cfg_i.margin_top) : pen_y_q + 17'(cfg_i.line_pitch);
  assign glyph_x = wrap ? adv_x : pen_x_q;
  assign glyph_y = wrap ? adv_y : pen_y_q;

  always_comb begin
    pend_d   = pend_q;
    grab_d   = grab_q;
    ul_d     = ul_q;
    intl_d   = intl_q;
    drop_d   = drop_q;
    do_glyph = 1'b0;
    do_eol   = 1'b0;

    if (drop_q) begin
      if (last_i) drop_d = 1'b0;
    end else if (grab_q) begin
      grab_d = 1'b0;
      if (is_esc_code) pend_d = 1'b0;
      else do_glyph = 1'b1;
    end else begin
      case (byte_i) inside
        pep_pkg::CODE_UL_ON:  ul_d = 1'b1;
        pep_pkg::CODE_UL_OFF: ul_d = 1'b0;
        pep_pkg::CODE_INTL_ON, pep_pkg::CODE_INTL_OFF,
        pep_pkg::CODE_ESC_UL_ON, pep_pkg::CODE_ESC_UL_OFF: begin
          if (pend_q) pend_d = 1'b0;
          else do_glyph = 1'b1;
        end
        pep_pkg::CODE_EOL: begin
          pend_d = 1'b0;
          grab_d = 1'b0;
          ul_d   = 1'b0;
          drop_d = !last_i;
          do_eol = 1'b1;
        end
        pep_pkg::CODE_ESC: begin
          if (pend_q) begin
            pend_d   = 1'b0;
            do_glyph = 1'b1;
          end else begin
            pend_d = 1'b1;
            grab_d = !last_i;
          end
        end
        default: do_glyph = 1'b1;
      endcase
    end

    // Mode change of an escaped code, taken when the code is consumed as such
    if (!drop_q && is_esc_code && (grab_q || pend_q)) begin
      case (byte_i)
        pep_pkg::CODE_INTL_ON:    intl_d = 1'b1;
        pep_pkg::CODE_INTL_OFF:   intl_d = 1'b0;
        pep_pkg::CODE_ESC_UL_ON:  ul_d   = 1'b1;
        pep_pkg::CODE_ESC_UL_OFF: ul_d   = 1'b0;
        default: ;
      endcase
    end

    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    if (do_eol) begin
      pen_x_d = adv_x;
      pen_y_d = adv_y;
    end else if (do_glyph) begin
      pen_x_d = glyph_x + 17'(cfg_i.char_width);
      pen_y_d = glyph_y;
    end
  end

  always_comb begin
    res_o.kind         = do_eol ? pep_pkg::KIND_EOL : pep_pkg::KIND_GLYPH;
    res_o.new_page     = do_eol ? eject : (wrap && eject);
    res_o.glyph_code   = do_eol ? 8'd0 : byte_i;
    res_o.draw_x       = do_eol ? 16'd0 : glyph_x[15:0];
    res_o.draw_y       = do_eol ? 17'd0 : glyph_y + 17'(cfg_i.char_height);
    res_o.underline_on = do_eol ? 1'b0 : ul_q;
    res_o.intl_on      = intl_q;
  end

  assign emit_o = do_glyph || do_eol;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      grab_q  <= 1'b0;
      ul_q    <= 1'b0;
      intl_q  <= 1'b0;
      drop_q  <= 1'b0;
      pen_x_q <= 17'(pep_pkg::MARGIN_LEFT_RST);
      pen_y_q <= 17'(pep_pkg::MARGIN_TOP_RST);
    end else if (step_i) begin
      pend_q  <= pend_d;
      grab_q  <= grab_d;
      ul_q    <= ul_d;
      intl_q  <= intl_d;
      drop_q  <= drop_d;
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A grabbed byte always follows an unresolved ESC
  a_grab_implies_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grab_q |-> pend_q) else $error("grab set without pending ESC");

  // Skipping the buffer tail and grabbing after ESC never overlap
  a_drop_grab_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(drop_q && grab_q)) else $error("drop and grab both set");

  // An end of line always leaves underline off
  a_eol_clears_ul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && do_eol) |=> !ul_q) else $error("underline survived end of line");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the printer escape parser and layout block.
// ----------------------------------------------------------------------------
// A table of directed bytes covers the control codes, escape sequences,
// escapes left open at the end of a buffer, dropped bytes after an end of
// line, and the byte range extremes. A few rows carry a hand-typed result.
// Then random bytes follow under several page layouts, including an inverted
// box and the largest glyph sizes. These are mostly text runs, escape
// sequences and line ends, with noise in between. A behavioural model of the
// parser and the pen predicts every result of the untyped bytes. The output
// stream is compared in order against the predicted and typed results.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned N_ROWS       = 25;
  localparam int unsigned N_REGS       = 7;
  localparam int unsigned N_LAYOUTS    = 7;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned PHASE_BYTES  = 105;
  localparam int unsigned CALM_LAYOUT  = 2;

  // One directed stimulus row; want is only used when typed is set
  typedef struct packed {
    logic [7:0]    code;
    logic          last;
    logic          typed;
    pep_pkg::res_t want;
  } row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [pep_pkg::TDATA_IN_W-1:0]  s_axis_tdata;   // [7:0] data_byte
  logic                            s_axis_tlast;   // last_in_buffer
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [0] new_page, [8:1] glyph_code, [24:9] draw_x, [41:25] draw_y,
  // [42] underline_on, [43] intl_on, [47:44] zero
  logic [pep_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;   // [0] kind
  logic                            cfg_we_i;
  logic [pep_pkg::CFG_IDX_W-1:0]   cfg_idx_i;
  logic [pep_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  printer_escape_parser_layout dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  pep_pkg::res_t due_prints [$];  // results still owed by the block, oldest first
  int unsigned bad_prints = 0;
  int unsigned parsed_cnt = 0;  // bytes that reached the parser (not dropped)
  int unsigned cycle_cnt  = 0;
  int unsigned idle_pct   = 13; // chance in a hundred that a side idles

  // Predictor copy of the layout registers and the parser state
  pep_pkg::cfg_t lay;
  logic        esc_open;       // ESC seen, not yet resolved
  logic        esc_take_next;  // next byte belongs to the ESC
  logic        ul_on;
  logic        intl_on_q;
  logic        skip_buf;       // skip up to the end of the host buffer
  logic [16:0] cur_x;
  logic [16:0] cur_y;

  localparam logic [pep_pkg::CFG_IDX_W-1:0] REG_ORDER [N_REGS] = '{
    pep_pkg::REG_MARGIN_LEFT, pep_pkg::REG_MARGIN_RIGHT, pep_pkg::REG_MARGIN_TOP,
    pep_pkg::REG_MARGIN_BOTTOM, pep_pkg::REG_CHAR_WIDTH, pep_pkg::REG_CHAR_HEIGHT,
    pep_pkg::REG_LINE_PITCH
  };

  // Layout sets in register order: left, right, top, bottom, width, height,
  // pitch. The last two are drawn at random before use.
  logic [15:0] layout_sets [N_LAYOUTS][N_REGS] = '{
    '{16'd5,     16'd100,   16'd3,     16'd200,   16'd7,    16'd9,    16'd11},
    // inverted box: every glyph wraps and every line ejects the page
    '{16'd65535, 16'd0,     16'd65535, 16'd0,     16'd1023, 16'd1023, 16'd1023},
    '{16'd0,     16'd65535, 16'd0,     16'd65535, 16'd1,    16'd1,    16'd1},
    '{16'd0,     16'd65535, 16'd60000, 16'd65535, 16'd1023, 16'd1023, 16'd1023},
    '{16'd300,   16'd420,   16'd500,   16'd700,   16'd12,   16'd30,   16'd25},
    '{16'd0,     16'd0,     16'd0,     16'd0,     16'd1,    16'd1,    16'd1},
    '{16'd0,     16'd0,     16'd0,     16'd0,     16'd1,    16'd1,    16'd1}
  };

  // Directed table under the reset layout (left 0, right 960, top 0,
  // bottom 1320, width 10, height 17, pitch 19)
  row_t dir_rows [N_ROWS] = '{
    '{8'd65,                    1'b0, 1'b1,
      '{pep_pkg::KIND_GLYPH, 1'b0, 8'd65, 16'd0, 17'd17, 1'b0, 1'b0}},
    '{pep_pkg::CODE_UL_ON,      1'b0, 1'b0, '0},
    '{8'd66,                    1'b0, 1'b1,
      '{pep_pkg::KIND_GLYPH, 1'b0, 8'd66, 16'd10, 17'd17, 1'b1, 1'b0}},
    '{pep_pkg::CODE_UL_OFF,     1'b0, 1'b0, '0},
    '{pep_pkg::CODE_ESC,        1'b0, 1'b0, '0},
    '{pep_pkg::CODE_INTL_ON,    1'b0, 1'b0, '0},
    '{8'd0,                     1'b0, 1'b1,
      '{pep_pkg::KIND_GLYPH, 1'b0, 8'd0, 16'd20, 17'd17, 1'b0, 1'b1}},
    '{pep_pkg::CODE_ESC,        1'b0, 1'b0, '0},
    '{pep_pkg::CODE_ESC_UL_ON,  1'b0, 1'b0, '0},
    // end of line grabbed straight after an ESC is printed, ESC stays open
    '{pep_pkg::CODE_ESC,        1'b0, 1'b0, '0},
    '{pep_pkg::CODE_EOL,        1'b0, 1'b0, '0},
    '{pep_pkg::CODE_INTL_OFF,   1'b0, 1'b0, '0},
    // ESC closing a buffer stays open across a later glyph until a mode code resolves it
    '{pep_pkg::CODE_ESC,        1'b1, 1'b0, '0},
    '{8'd255,                   1'b1, 1'b0, '0},
    '{pep_pkg::CODE_ESC_UL_OFF, 1'b1, 1'b0, '0},
    '{pep_pkg::CODE_ESC,        1'b1, 1'b0, '0},
    '{pep_pkg::CODE_ESC,        1'b0, 1'b0, '0},
    // mode code with no ESC open is just a glyph
    '{pep_pkg::CODE_INTL_ON,    1'b0, 1'b0, '0},
    '{pep_pkg::CODE_UL_ON,      1'b0, 1'b0, '0},
    // end of line mid-buffer: skip up to the buffer's last byte
    '{pep_pkg::CODE_EOL,        1'b0, 1'b1,
      '{pep_pkg::KIND_EOL, 1'b0, 8'd0, 16'd0, 17'd0, 1'b0, 1'b0}},
    '{8'd65,                    1'b0, 1'b0, '0},
    '{pep_pkg::CODE_ESC,        1'b0, 1'b0, '0},
    '{8'd66,                    1'b1, 1'b0, '0},
    '{pep_pkg::CODE_EOL,        1'b1, 1'b1,
      '{pep_pkg::KIND_EOL, 1'b0, 8'd0, 16'd0, 17'd0, 1'b0, 1'b0}},
    '{8'd128,                   1'b1, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Carriage return and line feed; returns 1 when the page is ejected
  function automatic logic feed_line();
    logic ejected;
    ejected = 1'b0;
    cur_x = 17'(lay.margin_left);
    if (32'(cur_y) + 32'(lay.char_height) > 32'(lay.margin_bottom)) begin
      ejected = 1'b1;
      cur_y = 17'(lay.margin_top);
    end else begin
      cur_y = cur_y + 17'(lay.line_pitch);
    end
    return ejected;
  endfunction

  // Apply a mode code that follows an ESC; returns 0 if it is no such code
  function automatic logic apply_escape(logic [7:0] code);
    case (code)
      pep_pkg::CODE_ESC_UL_ON:  ul_on = 1'b1;
      pep_pkg::CODE_ESC_UL_OFF: ul_on = 1'b0;
      pep_pkg::CODE_INTL_ON:    intl_on_q = 1'b1;
      pep_pkg::CODE_INTL_OFF:   intl_on_q = 1'b0;
      default:                  return 1'b0;
    endcase
    esc_open = 1'b0;
    return 1'b1;
  endfunction

  // Place one glyph at the pen, wrapping first if it would pass the margin
  function automatic pep_pkg::res_t place_glyph(logic [7:0] code);
    pep_pkg::res_t r;
    r = '0;
    if (32'(cur_x) + 32'(lay.char_width) > 32'(lay.margin_right))
      r.new_page = feed_line();
    r.kind         = pep_pkg::KIND_GLYPH;
    r.glyph_code   = code;
    r.draw_x       = cur_x[15:0];
    r.draw_y       = cur_y + 17'(lay.char_height);
    r.underline_on = ul_on;
    r.intl_on      = intl_on_q;
    cur_x = cur_x + 17'(lay.char_width);
    return r;
  endfunction

  // Lay out one byte; hit says whether it yields a result
  task automatic layout_byte(input logic [7:0] code, input logic last,
                             output logic dropped, output logic hit,
                             output pep_pkg::res_t r);
    dropped = 1'b0;
    hit     = 1'b0;
    r       = '0;
    if (skip_buf) begin
      if (last)
        skip_buf = 1'b0;
      dropped = 1'b1;
      return;
    end
    if (esc_take_next) begin
      esc_take_next = 1'b0;
      if (!apply_escape(code)) begin
        hit = 1'b1;
        r   = place_glyph(code);
      end
      return;
    end
    case (code) inside
      pep_pkg::CODE_UL_ON:  ul_on = 1'b1;
      pep_pkg::CODE_UL_OFF: ul_on = 1'b0;
      pep_pkg::CODE_INTL_ON, pep_pkg::CODE_INTL_OFF,
      pep_pkg::CODE_ESC_UL_ON, pep_pkg::CODE_ESC_UL_OFF: begin
        if (esc_open) begin
          void'(apply_escape(code));
        end else begin
          hit = 1'b1;
          r   = place_glyph(code);
        end
      end
      pep_pkg::CODE_EOL: begin
        esc_open      = 1'b0;
        esc_take_next = 1'b0;
        ul_on         = 1'b0;
        hit           = 1'b1;
        r.kind        = pep_pkg::KIND_EOL;
        r.new_page    = feed_line();
        r.intl_on     = intl_on_q;
        skip_buf      = !last;
      end
      pep_pkg::CODE_ESC: begin
        if (esc_open) begin
          esc_open = 1'b0;
          hit      = 1'b1;
          r        = place_glyph(code);
        end else begin
          esc_open      = 1'b1;
          esc_take_next = !last;
        end
      end
      default: begin
        hit = 1'b1;
        r   = place_glyph(code);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Byte source
  // --------------------------------------------------------------------------

  // Offer one byte, idling at random first; returns at the falling edge after
  // the transaction. A typed row owes its literal result instead.
  task automatic send_byte(input logic [7:0] code, input logic last,
                           input logic typed, input pep_pkg::res_t want);
    logic dropped;
    logic hit;
    pep_pkg::res_t r;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    layout_byte(code, last, dropped, hit, r);
    if (typed)
      due_prints.push_back(want);
    else if (hit)
      due_prints.push_back(r);
    if (!dropped)
      parsed_cnt++;
    @(negedge clk_i);
  endtask

  function automatic logic buf_end();
    return $urandom_range(7) == 0;
  endfunction

  // Random traffic: mostly text runs and escape sequences, some line ends
  // and underline codes, and raw noise over the full byte range
  task automatic spray_bytes(input int unsigned goal);
    int unsigned start;
    int unsigned pick;
    start = parsed_cnt;
    while (parsed_cnt - start < goal) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        repeat ($urandom_range(1, 8))
          send_byte(8'($urandom_range(32, 126)), buf_end(), 1'b0, '0);
      end else if (pick < 60) begin
        send_byte(pep_pkg::CODE_ESC, $urandom_range(9) == 0, 1'b0, '0);
        if (pick < 57)
          send_byte(pep_pkg::CODE_INTL_ON + 8'($urandom_range(3)), buf_end(), 1'b0, '0);
        else
          send_byte(8'($urandom_range(255)), buf_end(), 1'b0, '0);
      end else if (pick < 64) begin
        send_byte(pep_pkg::CODE_ESC, buf_end(), 1'b0, '0);
        send_byte(pep_pkg::CODE_ESC, buf_end(), 1'b0, '0);
      end else if (pick < 70) begin
        send_byte(pick[0] ? pep_pkg::CODE_UL_ON : pep_pkg::CODE_UL_OFF, buf_end(),
                  1'b0, '0);
      end else if (pick < 80) begin
        send_byte(pep_pkg::CODE_EOL, $urandom_range(3) == 0, 1'b0, '0);
      end else begin
        send_byte(8'($urandom_range(255)), buf_end(), 1'b0, '0);
      end
    end
  endtask

  // Hold the source off, wait for every owed result, then let the block
  // finish any byte that yields nothing
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_prints.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  // Write all seven layout registers from one set, one per cycle
  task automatic load_layout(input int unsigned s);
    for (int i = 0; i < N_REGS; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_ORDER[i];
      cfg_data_i <= layout_sets[s][i];
      case (REG_ORDER[i])
        pep_pkg::REG_MARGIN_LEFT:   lay.margin_left   = layout_sets[s][i];
        pep_pkg::REG_MARGIN_RIGHT:  lay.margin_right  = layout_sets[s][i];
        pep_pkg::REG_MARGIN_TOP:    lay.margin_top    = layout_sets[s][i];
        pep_pkg::REG_MARGIN_BOTTOM: lay.margin_bottom = layout_sets[s][i];
        pep_pkg::REG_CHAR_WIDTH:    lay.char_width    = layout_sets[s][i][9:0];
        pep_pkg::REG_CHAR_HEIGHT:   lay.char_height   = layout_sets[s][i][9:0];
        pep_pkg::REG_LINE_PITCH:    lay.line_pitch    = layout_sets[s][i][9:0];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random back-pressure, checked at the rising edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk_i) begin
    pep_pkg::res_t got;
    pep_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind         = m_axis_tuser;
      got.new_page     = m_axis_tdata[0];
      got.glyph_code   = m_axis_tdata[8:1];
      got.draw_x       = m_axis_tdata[24:9];
      got.draw_y       = m_axis_tdata[41:25];
      got.underline_on = m_axis_tdata[42];
      got.intl_on      = m_axis_tdata[43];
      if (due_prints.size() == 0) begin
        bad_prints++;
        $display("%0t: result with none owed: kind=%0d code=%0d x=%0d y=%0d",
                 $time, got.kind, got.glyph_code, got.draw_x, got.draw_y);
      end else begin
        want = due_prints.pop_front();
        if (got !== want) begin
          bad_prints++;
          $display("%0t: result mismatch", $time);
          $display("  expected kind=%0d page=%0d code=%0d x=%0d y=%0d ul=%0d intl=%0d",
                   want.kind, want.new_page, want.glyph_code, want.draw_x,
                   want.draw_y, want.underline_on, want.intl_on);
          $display("  actual   kind=%0d page=%0d code=%0d x=%0d y=%0d ul=%0d intl=%0d",
                   got.kind, got.new_page, got.glyph_code, got.draw_x,
                   got.draw_y, got.underline_on, got.intl_on);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = pep_pkg::REG_MARGIN_LEFT;
    cfg_data_i    = '0;

    // Predictor starts from the reset layout with the pen at the top left
    lay.margin_left   = pep_pkg::MARGIN_LEFT_RST;
    lay.margin_right  = pep_pkg::MARGIN_RIGHT_RST;
    lay.margin_top    = pep_pkg::MARGIN_TOP_RST;
    lay.margin_bottom = pep_pkg::MARGIN_BOTTOM_RST;
    lay.char_width    = pep_pkg::CHAR_WIDTH_RST;
    lay.char_height   = pep_pkg::CHAR_HEIGHT_RST;
    lay.line_pitch    = pep_pkg::LINE_PITCH_RST;
    esc_open      = 1'b0;
    esc_take_next = 1'b0;
    ul_on         = 1'b0;
    intl_on_q     = 1'b0;
    skip_buf      = 1'b0;
    cur_x         = 17'(pep_pkg::MARGIN_LEFT_RST);
    cur_y         = 17'(pep_pkg::MARGIN_TOP_RST);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    for (int i = 0; i < N_ROWS; i++)
      send_byte(dir_rows[i].code, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].want);

    // Random traffic, one layout per phase
    for (int s = 0; s < N_LAYOUTS; s++) begin
      if (s >= N_LAYOUTS - 2) begin
        layout_sets[s][0] = 16'($urandom_range(0, 400));
        layout_sets[s][1] = layout_sets[s][0] + 16'($urandom_range(0, 600));
        layout_sets[s][2] = 16'($urandom_range(0, 400));
        layout_sets[s][3] = layout_sets[s][2] + 16'($urandom_range(0, 800));
        layout_sets[s][4] = 16'($urandom_range(1, 40));
        layout_sets[s][5] = 16'($urandom_range(1, 60));
        layout_sets[s][6] = 16'($urandom_range(1, 60));
      end
      settle();
      load_layout(s);
      // one phase runs with neither side idling
      idle_pct = (s == CALM_LAYOUT) ? 0 : 13;
      spray_bytes(PHASE_BYTES);
    end

    settle();
    if (bad_prints == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
